/* hdl/light_triggered_stepper_blind_top_assert.svh */
// Assertion macros used by the blind controller checker
`ifndef LIGHT_TRIGGERED_STEPPER_BLIND_TOP_ASSERT_SVH
`define LIGHT_TRIGGERED_STEPPER_BLIND_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clock, off while reset is high
`define LTSB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high
`define LTSB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/ltsb_pkg.sv */
// Constants, types and the coil table of the blind controller
package ltsb_pkg;

   localparam int THRESH_W   = 10;
   localparam int STEPS_W    = 16;
   localparam int PHASE_W    = 3;
   localparam int COIL_W     = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef logic [THRESH_W-1:0]   thresh_type;
   typedef logic [STEPS_W-1:0]    steps_type;
   typedef logic [PHASE_W-1:0]    phase_type;
   typedef logic [COIL_W-1:0]     coil_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   localparam thresh_type THRESH_RESET = thresh_type'(400);
   localparam steps_type  STEPS_RESET  = steps_type'(3000);

   // register indexes
   localparam csr_idx_type CSR_THRESHOLD   = csr_idx_type'(0);
   localparam csr_idx_type CSR_OPEN_STEPS  = csr_idx_type'(1);
   localparam csr_idx_type CSR_CLOSE_STEPS = csr_idx_type'(2);

   // request codes
   localparam logic REQ_TICK   = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   // direction codes
   localparam logic DIR_FWD  = 1'b0;
   localparam logic DIR_BACK = 1'b1;

   // half-step coil sequence
   function automatic coil_type coil_of(input phase_type phase);
      coil_type c;
      case (phase)
         3'd0:    c = 4'b1000;
         3'd1:    c = 4'b1100;
         3'd2:    c = 4'b0100;
         3'd3:    c = 4'b0110;
         3'd4:    c = 4'b0010;
         3'd5:    c = 4'b0011;
         3'd6:    c = 4'b0001;
         3'd7:    c = 4'b1001;
         default: c = 4'b0000;
      endcase
      return c;
   endfunction

endpackage

/* hdl/ltsb_req_if.sv */
// Request channel: step ticks and light samples
interface ltsb_req_if #(
   parameter int LIGHT_BITS = 10
);
   logic                  valid;
   logic                  ready;
   logic                  req_type;
   logic [LIGHT_BITS-1:0] light_level;

   modport source (output valid, output req_type, output light_level, input ready);
   modport sink   (input valid, input req_type, input light_level, output ready);
endinterface

/* hdl/ltsb_rsp_if.sv */
// Response channel: coil drive and blind status
interface ltsb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ltsb_pkg::COIL_W-1:0]   coil_pattern;
   logic                          blind_open;
   logic                          moving;

   modport source (output valid, output coil_pattern, output blind_open, output moving,
                   input ready);
   modport sink   (input valid, input coil_pattern, input blind_open, input moving,
                   output ready);
endinterface

/* hdl/light_triggered_stepper_blind_top.sv */
// Blind controller: light-triggered half-step stepper sequencer
//
//   port      dir   handshake       payload
//   req_bus   in    valid/ready     req_type, light_level
//   rsp_bus   out   valid/ready     coil_pattern, blind_open, moving
//   csr_*     in    csr_we          csr_index, csr_wdata
//
// One item per cycle unless rsp_bus stalls; each response is valid in the next cycle.
// The response comes from the single response register behind the state update.
// Reset (synchronous) closes the blind, stops any run and empties the response register.
// A stalled response holds; a new item is taken in the same cycle the response leaves.
module light_triggered_stepper_blind_top #(
   parameter int LIGHT_BITS = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   ltsb_req_if.sink                        req_bus,
   ltsb_rsp_if.source                      rsp_bus,
   input  logic                            csr_we,
   input  logic [ltsb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ltsb_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CmpW = (LIGHT_BITS > ltsb_pkg::THRESH_W) ? LIGHT_BITS : ltsb_pkg::THRESH_W;

   ltsb_pkg::thresh_type threshold_ff, threshold_in;
   ltsb_pkg::steps_type  open_steps_ff, open_steps_in;
   ltsb_pkg::steps_type  close_steps_ff, close_steps_in;

   logic                 open_ff, open_in;
   ltsb_pkg::phase_type  phase_ff, phase_in;
   ltsb_pkg::steps_type  steps_ff, steps_in;
   logic                 dir_ff, dir_in;
   ltsb_pkg::coil_type   coil_ff, coil_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   ltsb_pkg::coil_type   rsp_coil_ff, rsp_coil_in;
   logic                 rsp_open_ff, rsp_open_in;
   logic                 rsp_moving_ff, rsp_moving_in;

   logic                 accept;
   logic                 above;
   ltsb_pkg::phase_type  phase_step;
   ltsb_pkg::steps_type  run_count;
   logic                 run_dir;
   logic                 run_start;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   assign above = CmpW'(req_bus.light_level) > CmpW'(threshold_ff);

   assign phase_step = (dir_ff == ltsb_pkg::DIR_BACK)
                       ? ltsb_pkg::phase_type'(phase_ff - 1'b1)
                       : ltsb_pkg::phase_type'(phase_ff + 1'b1);

   // configuration writes
   always_comb begin
      threshold_in   = threshold_ff;
      open_steps_in  = open_steps_ff;
      close_steps_in = close_steps_ff;
      if (csr_we) begin
         case (csr_index)
            ltsb_pkg::CSR_THRESHOLD:   threshold_in   = csr_wdata[ltsb_pkg::THRESH_W-1:0];
            ltsb_pkg::CSR_OPEN_STEPS:  open_steps_in  = csr_wdata[ltsb_pkg::STEPS_W-1:0];
            ltsb_pkg::CSR_CLOSE_STEPS: close_steps_in = csr_wdata[ltsb_pkg::STEPS_W-1:0];
            default: ;
         endcase
      end
   end

   // pick the run a sample would start
   always_comb begin
      run_start = 1'b0;
      run_count = open_steps_ff;
      run_dir   = ltsb_pkg::DIR_FWD;
      if (above && !open_ff) begin
         run_start = 1'b1;
      end else if (!above && open_ff) begin
         run_start = 1'b1;
         run_count = close_steps_ff;
         run_dir   = ltsb_pkg::DIR_BACK;
      end
   end

   // state update per item
   always_comb begin
      open_in  = open_ff;
      phase_in = phase_ff;
      steps_in = steps_ff;
      dir_in   = dir_ff;
      coil_in  = coil_ff;
      if (accept) begin
         if (req_bus.req_type == ltsb_pkg::REQ_TICK) begin
            if (steps_ff != '0) begin
               phase_in = phase_step;
               coil_in  = ltsb_pkg::coil_of(phase_step);
               steps_in = ltsb_pkg::steps_type'(steps_ff - 1'b1);
               if (steps_ff == ltsb_pkg::steps_type'(1)) begin
                  open_in = !open_ff;
               end
            end
         end else if (steps_ff == '0 && run_start) begin
            // zero-length run flips the flag at once
            if (run_count == '0) begin
               open_in = !open_ff;
            end else begin
               steps_in = run_count;
               dir_in   = run_dir;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_coil_in   = rsp_coil_ff;
      rsp_open_in   = rsp_open_ff;
      rsp_moving_in = rsp_moving_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_coil_in   = coil_in;
         rsp_open_in   = open_in;
         rsp_moving_in = steps_in != '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= ltsb_pkg::THRESH_RESET;
         open_steps_ff  <= ltsb_pkg::STEPS_RESET;
         close_steps_ff <= ltsb_pkg::STEPS_RESET;
         open_ff        <= 1'b0;
         phase_ff       <= '0;
         steps_ff       <= '0;
         dir_ff         <= ltsb_pkg::DIR_FWD;
         coil_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         threshold_ff   <= threshold_in;
         open_steps_ff  <= open_steps_in;
         close_steps_ff <= close_steps_in;
         open_ff        <= open_in;
         phase_ff       <= phase_in;
         steps_ff       <= steps_in;
         dir_ff         <= dir_in;
         coil_ff        <= coil_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_coil_ff   <= rsp_coil_in;
      rsp_open_ff   <= rsp_open_in;
      rsp_moving_ff <= rsp_moving_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.coil_pattern = rsp_coil_ff;
   assign rsp_bus.blind_open   = rsp_open_ff;
   assign rsp_bus.moving       = rsp_moving_ff;

endmodule

/* hdl/ltsb_checker.sv */
// Port-level checker for the blind controller, bound to the top level
`include "light_triggered_stepper_blind_top_assert.svh"

module ltsb_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [ltsb_pkg::COIL_W-1:0]   coil_pattern,
   input logic                          blind_open,
   input logic                          moving
);

   logic [ltsb_pkg::COIL_W+1:0] rsp_payload;
   logic                        rsp_stall;
   logic                        coil_ok;

   assign rsp_payload = {coil_pattern, blind_open, moving};
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign coil_ok     = coil_pattern inside {4'b0000, 4'b1000, 4'b1100, 4'b0100, 4'b0110,
                                             4'b0010, 4'b0011, 4'b0001, 4'b1001};

   `LTSB_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_payload), "stalled item changed")

   `LTSB_ASSERT_NEXT(a_rsp_follows, req_valid && req_ready, rsp_valid, "taken item gave no result")

   `LTSB_ASSERT_NOW(a_coil_legal, rsp_valid, coil_ok, "coil pattern outside half-step sequence")

   `LTSB_ASSERT_NOW(a_ready_free, !rsp_valid || rsp_ready, req_ready, "input stalled, output free")

endmodule

bind light_triggered_stepper_blind_top ltsb_checker u_ltsb_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .coil_pattern (rsp_bus.coil_pattern),
   .blind_open   (rsp_bus.blind_open),
   .moving       (rsp_bus.moving)
);
